FILE: sv/m3i_pkg.sv
// m3i_pkg: types, widths and constants shared by the 3x3 matrix inverse
// pipeline (matrix3x3_inverse and its divider lane m3i_div)
// no dependencies
`default_nettype none

package m3i_pkg;

  localparam int FRAC_BITS = 16;

  // adjugate magnitude, determinant magnitude, shifted dividend
  localparam int AW = 64;
  localparam int DW = 96;
  localparam int NW = AW + 2 * FRAC_BITS;
  // quotient bits formed before rounding (enough to decide saturation)
  localparam int QW = 33;
  // width used for the up-front saturation compare
  localparam int CW = ((NW - QW) > DW) ? (NW - QW) : DW;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // cofactor k = m[a]*m[b] - m[c]*m[d], adjugate in row order
  localparam int COF_SEL [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic               invertible;
  } out_t;

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] a_mag;
    logic          a_neg;
    logic [DW-1:0] d_mag;
    logic          d_neg;
    logic          sing;
  } div_in_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] quo;
    logic               ok;
  } div_out_t;

endpackage

`default_nettype wire

FILE: sv/m3i_div.sv
// m3i_div: one pipelined divider lane, rounded and saturated Q quotient
// of adjugate / determinant, one quotient bit per stage
// depends on m3i_pkg
`default_nettype none

module m3i_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire m3i_pkg::div_in_t   div_i,
  output m3i_pkg::div_out_t       div_o
);

  typedef struct packed {
    logic [m3i_pkg::DW-1:0] r;
    logic [m3i_pkg::DW-1:0] d;
    logic [m3i_pkg::QW-1:0] q;
    logic [m3i_pkg::QW-1:0] nlow;
    logic                   neg;
    logic                   sat;
    logic                   sing;
  } step_t;

  step_t st_r [m3i_pkg::QW+1];
  logic  vld_r [m3i_pkg::QW+1];

  // front stage: dividend top part and saturation check
  logic [m3i_pkg::NW-1:0]          nfull;
  logic [m3i_pkg::NW-m3i_pkg::QW-1:0] ntop;
  step_t                           pre_nxt;

  always_comb begin
    nfull = {div_i.a_mag, {(2 * m3i_pkg::FRAC_BITS){1'b0}}};
    ntop  = nfull[m3i_pkg::NW-1:m3i_pkg::QW];
    pre_nxt.r    = m3i_pkg::DW'(ntop);
    pre_nxt.d    = div_i.d_mag;
    pre_nxt.q    = '0;
    pre_nxt.nlow = nfull[m3i_pkg::QW-1:0];
    pre_nxt.neg  = div_i.a_neg ^ div_i.d_neg;
    pre_nxt.sat  = m3i_pkg::CW'(ntop) >= m3i_pkg::CW'(div_i.d_mag);
    pre_nxt.sing = div_i.sing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= div_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r[0] <= pre_nxt;
  end

  // restoring steps, quotient bit QW-k at stage k
  for (genvar k = 1; k <= m3i_pkg::QW; k++) begin : g_step
    logic [m3i_pkg::DW:0] t;
    logic [m3i_pkg::DW:0] diff;
    logic                 ge;
    step_t                s_nxt;

    always_comb begin
      t     = {st_r[k-1].r, st_r[k-1].nlow[m3i_pkg::QW-k]};
      diff  = t - {1'b0, st_r[k-1].d};
      ge    = t >= {1'b0, st_r[k-1].d};
      s_nxt = st_r[k-1];
      s_nxt.r = ge ? diff[m3i_pkg::DW-1:0] : t[m3i_pkg::DW-1:0];
      s_nxt.q = {st_r[k-1].q[m3i_pkg::QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      st_r[k] <= s_nxt;
    end
  end

  // rounding stage, half up on the remainder
  logic                 rnd_vld_r;
  logic [m3i_pkg::QW:0] qr_r, qr_nxt;
  logic                 rnd_neg_r, rnd_sat_r, rnd_sing_r;

  always_comb begin
    qr_nxt = {1'b0, st_r[m3i_pkg::QW].q}
           + (m3i_pkg::QW+1)'({st_r[m3i_pkg::QW].r, 1'b0} >= {1'b0, st_r[m3i_pkg::QW].d});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= 1'b0;
    end else begin
      rnd_vld_r <= vld_r[m3i_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    qr_r       <= qr_nxt;
    rnd_neg_r  <= st_r[m3i_pkg::QW].neg;
    rnd_sat_r  <= st_r[m3i_pkg::QW].sat;
    rnd_sing_r <= st_r[m3i_pkg::QW].sing;
  end

  // sign, saturation and singular zeroing
  logic               out_vld_r;
  logic signed [31:0] quo_r, quo_nxt;
  logic               ok_r;
  logic               over_p, over_n;

  always_comb begin
    over_p = rnd_sat_r || (qr_r > {2'b00, m3i_pkg::SAT_POS});
    over_n = rnd_sat_r || (qr_r > {2'b00, m3i_pkg::SAT_NEG});
    if (rnd_sing_r) begin
      quo_nxt = '0;
    end else if (rnd_neg_r) begin
      quo_nxt = over_n ? m3i_pkg::SAT_NEG : (32'd0 - qr_r[31:0]);
    end else begin
      quo_nxt = over_p ? m3i_pkg::SAT_POS : qr_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= rnd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    ok_r  <= !rnd_sing_r;
  end

  assign div_o.valid = out_vld_r;
  assign div_o.quo   = quo_r;
  assign div_o.ok    = ok_r;

endmodule

`default_nettype wire

FILE: sv/matrix3x3_inverse.sv
// matrix3x3_inverse: top level, cofactor and determinant pipeline feeding
// nine divider lanes
// depends on m3i_pkg and m3i_div
`default_nettype none

// usage
//   input channel: an item (nine signed Q16.16 elements, row by row in
//   in_data) is taken at each rising edge with start high; busy is tied low,
//   so an item may be offered in every cycle
//   result channel: out_strobe is high for one cycle with the inverse and
//   the invertible flag in out_data
//   pipeline: the 33-stage bit-per-stage divider lanes plus stages of
//   multiply, add, compare, rounding and saturation
//   throughput: one item per cycle, every stage takes a new item each cycle
//   configuration: cfg_we with cfg_wdata writes the singular threshold
//   (Q16.16 magnitude); write it only while no item is in flight
//   reset: rst_n low clears every valid bit and sets the threshold to 1;
//   items in flight are dropped
//   the receiver cannot stall, so results leave the pipeline as they finish
//   singular or near-singular matrices give all-zero elements, invertible low

module matrix3x3_inverse (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire m3i_pkg::in_t    in_data,
  output logic                 out_strobe,
  output m3i_pkg::out_t        out_data,
  input  wire logic            cfg_we,
  input  wire logic [30:0]     cfg_wdata
);

  // threshold register
  logic [30:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 31'd1;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // never holds items off
  assign busy = 1'b0;

  // stage 0: input register
  logic          v0_r;
  m3i_pkg::in_t  in_r;
  logic signed [31:0] m [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_data;
    end
  end

  assign m[0] = in_r.m00;
  assign m[1] = in_r.m01;
  assign m[2] = in_r.m02;
  assign m[3] = in_r.m10;
  assign m[4] = in_r.m11;
  assign m[5] = in_r.m12;
  assign m[6] = in_r.m20;
  assign m[7] = in_r.m21;
  assign m[8] = in_r.m22;

  // stage 1: the eighteen element products
  logic               v1_r;
  logic signed [63:0] prod_r [18];
  logic signed [31:0] row1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      prod_r[2*k]   <= m[m3i_pkg::COF_SEL[k][0]] * m[m3i_pkg::COF_SEL[k][1]];
      prod_r[2*k+1] <= m[m3i_pkg::COF_SEL[k][2]] * m[m3i_pkg::COF_SEL[k][3]];
    end
    for (int k = 0; k < 3; k++) begin
      row1_r[k] <= m[k];
    end
  end

  // stage 2: exact cofactors, the adjugate
  logic               v2_r;
  logic signed [64:0] cof2_r [9];
  logic signed [31:0] row2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      cof2_r[k] <= 65'(prod_r[2*k]) - 65'(prod_r[2*k+1]);
    end
    row2_r <= row1_r;
  end

  // stage 3: first-row expansion, each 32 x 65 product split in two halves
  logic               v3_r;
  logic signed [64:0] ph_r [3];
  logic signed [64:0] pl_r [3];
  logic signed [64:0] cof3_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ph_r[k] <= 65'(row2_r[k] * $signed(cof2_r[3*k][64:32]));
      pl_r[k] <= 65'(row2_r[k] * $signed({1'b0, cof2_r[3*k][31:0]}));
    end
    cof3_r <= cof2_r;
  end

  // stage 4: recombine the halves
  logic               v4_r;
  logic signed [97:0] pd_r [3];
  logic signed [64:0] cof4_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pd_r[k] <= ($signed({{33{ph_r[k][64]}}, ph_r[k]}) <<< 32)
               + $signed({{33{pl_r[k][64]}}, pl_r[k]});
    end
    cof4_r <= cof3_r;
  end

  // stage 5: determinant
  logic               v5_r;
  logic signed [97:0] det5_r;
  logic signed [64:0] cof5_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    det5_r <= pd_r[0] + pd_r[1] + pd_r[2];
    cof5_r <= cof4_r;
  end

  // stage 6: magnitudes and signs
  logic                   v6_r;
  logic [m3i_pkg::DW-1:0] dmag6_r;
  logic                   dneg6_r;
  logic [m3i_pkg::AW-1:0] amag6_r [9];
  logic                   aneg6_r [9];
  logic signed [97:0]     dabs_nxt;
  logic signed [64:0]     aabs_nxt [9];

  always_comb begin
    dabs_nxt = det5_r[97] ? -det5_r : det5_r;
    for (int k = 0; k < 9; k++) begin
      aabs_nxt[k] = cof5_r[k][64] ? -cof5_r[k] : cof5_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    dmag6_r <= dabs_nxt[m3i_pkg::DW-1:0];
    dneg6_r <= det5_r[97];
    for (int k = 0; k < 9; k++) begin
      amag6_r[k] <= aabs_nxt[k][m3i_pkg::AW-1:0];
      aneg6_r[k] <= cof5_r[k][64];
    end
  end

  // stage 7: singular test against threshold, zero determinant included
  logic                   v7_r;
  logic [m3i_pkg::DW-1:0] dmag7_r;
  logic                   dneg7_r;
  logic [m3i_pkg::AW-1:0] amag7_r [9];
  logic                   aneg7_r [9];
  logic                   sing7_r, sing_nxt;
  logic [m3i_pkg::DW-1:0] limit;

  always_comb begin
    limit    = m3i_pkg::DW'(thr_r) << (2 * m3i_pkg::FRAC_BITS);
    sing_nxt = (dmag6_r == '0) || (dmag6_r < limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    dmag7_r <= dmag6_r;
    dneg7_r <= dneg6_r;
    amag7_r <= amag6_r;
    aneg7_r <= aneg6_r;
    sing7_r <= sing_nxt;
  end

  // nine divider lanes
  m3i_pkg::div_in_t  div_i [9];
  m3i_pkg::div_out_t div_o [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    assign div_i[k].valid = v7_r;
    assign div_i[k].a_mag = amag7_r[k];
    assign div_i[k].a_neg = aneg7_r[k];
    assign div_i[k].d_mag = dmag7_r;
    assign div_i[k].d_neg = dneg7_r;
    assign div_i[k].sing  = sing7_r;

    m3i_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .div_i (div_i[k]),
      .div_o (div_o[k])
    );
  end

  // every lane runs in lockstep, lane 0 carries the item's flags
  assign out_strobe          = div_o[0].valid;
  assign out_data.inv00      = div_o[0].quo;
  assign out_data.inv01      = div_o[1].quo;
  assign out_data.inv02      = div_o[2].quo;
  assign out_data.inv10      = div_o[3].quo;
  assign out_data.inv11      = div_o[4].quo;
  assign out_data.inv12      = div_o[5].quo;
  assign out_data.inv20      = div_o[6].quo;
  assign out_data.inv21      = div_o[7].quo;
  assign out_data.inv22      = div_o[8].quo;
  assign out_data.invertible = div_o[0].ok;

endmodule

`default_nettype wire

FILE: tb/sv/matrix3x3_inverse_checker.sv
`timescale 1ns / 100ps
// matrix3x3_inverse_checker: watches the item, result and threshold ports,
// predicts each inverse and compares it with what the block gives
// depends on m3i_pkg
`default_nettype none

module matrix3x3_inverse_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire m3i_pkg::in_t  in_data,
  input  wire logic          out_strobe,
  input  wire m3i_pkg::out_t out_data,
  input  wire logic          cfg_we,
  input  wire logic [30:0]   cfg_wdata,
  output int                 fail_count,
  output int                 pending_inverses,
  output int                 invertible_seen,
  output int                 singular_seen
);

  localparam int MINOR_SEL [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  logic [30:0]   threshold_copy;
  m3i_pkg::out_t inverse_queue[$];

  function automatic logic [31:0] divide_round_sat(logic signed [65:0] num,
                                                   logic signed [99:0] den);
    logic [127:0] n_mag, d_mag, q, r;
    logic         neg;
    neg   = (num < 0) != (den < 0);
    n_mag = (num < 0) ? 128'(-num) : 128'(num);
    d_mag = (den < 0) ? 128'(-den) : 128'(den);
    n_mag = n_mag << (2 * m3i_pkg::FRAC_BITS);
    q = n_mag / d_mag;
    r = n_mag % d_mag;
    if ((r << 1) >= d_mag) q = q + 1;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) return m3i_pkg::SAT_POS;
      return q[31:0];
    end
    if (q > 128'h8000_0000) return m3i_pkg::SAT_NEG;
    return 32'(0 - q[31:0]);
  endfunction

  function automatic m3i_pkg::out_t predict_inverse(m3i_pkg::in_t m, logic [30:0] thr);
    logic signed [31:0]  e [9];
    logic signed [65:0]  adj [9];
    logic signed [99:0]  det;
    logic [127:0]        det_mag, limit;
    logic [31:0]         q [9];
    m3i_pkg::out_t       res;
    e = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
    for (int k = 0; k < 9; k++)
      adj[k] = 66'(e[MINOR_SEL[k][0]]) * 66'(e[MINOR_SEL[k][1]])
             - 66'(e[MINOR_SEL[k][2]]) * 66'(e[MINOR_SEL[k][3]]);
    det = 100'(e[0]) * 100'(adj[0]) + 100'(e[1]) * 100'(adj[3])
        + 100'(e[2]) * 100'(adj[6]);
    det_mag = (det < 0) ? 128'(-det) : 128'(det);
    limit   = 128'(thr) << (2 * m3i_pkg::FRAC_BITS);
    res = '0;
    // zero determinant is singular whatever the threshold
    if (det == 0 || det_mag < limit) return res;
    for (int k = 0; k < 9; k++) q[k] = divide_round_sat(adj[k], det);
    res.inv00 = q[0]; res.inv01 = q[1]; res.inv02 = q[2];
    res.inv10 = q[3]; res.inv11 = q[4]; res.inv12 = q[5];
    res.inv20 = q[6]; res.inv21 = q[7]; res.inv22 = q[8];
    res.invertible = 1'b1;
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %h actual %h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    invertible_seen = 0;
    singular_seen = 0;
    pending_inverses = 0;
    threshold_copy = 31'd1;
  end

  always @(posedge clk) begin
    m3i_pkg::out_t want;
    if (!rst_n) begin
      threshold_copy = 31'd1;
      inverse_queue.delete();
    end else begin
      if (start && !busy)
        inverse_queue.push_back(predict_inverse(in_data, threshold_copy));
      if (out_strobe) begin
        if (inverse_queue.size() == 0) begin
          $error("result with no item waiting");
          fail_count++;
        end else begin
          want = inverse_queue.pop_front();
          compare_field("inv00", want.inv00, out_data.inv00);
          compare_field("inv01", want.inv01, out_data.inv01);
          compare_field("inv02", want.inv02, out_data.inv02);
          compare_field("inv10", want.inv10, out_data.inv10);
          compare_field("inv11", want.inv11, out_data.inv11);
          compare_field("inv12", want.inv12, out_data.inv12);
          compare_field("inv20", want.inv20, out_data.inv20);
          compare_field("inv21", want.inv21, out_data.inv21);
          compare_field("inv22", want.inv22, out_data.inv22);
          compare_field("invertible", 32'(want.invertible), 32'(out_data.invertible));
          if (want.invertible) invertible_seen++;
          else singular_seen++;
        end
      end
      if (cfg_we) threshold_copy = cfg_wdata;
    end
    pending_inverses = inverse_queue.size();
  end

endmodule

`default_nettype wire

FILE: tb/sv/matrix3x3_inverse_test.sv
`timescale 1ns / 100ps
// matrix3x3_inverse_test: stimulus and verdict for the 3x3 inverse block
// depends on m3i_pkg, matrix3x3_inverse and matrix3x3_inverse_checker
`default_nettype none

module matrix3x3_inverse_test;

  localparam int LATENCY_CYCLES = 43;
  localparam int RANDOM_ITEMS   = 580;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  m3i_pkg::in_t  in_data = '0;
  logic          out_strobe;
  m3i_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [30:0]   cfg_wdata = '0;
  int            fail_count, pending_inverses, invertible_seen, singular_seen;
  int            items_sent = 0;

  always #4 clk = ~clk;

  matrix3x3_inverse i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  matrix3x3_inverse_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_inverses(pending_inverses),
    .invertible_seen(invertible_seen), .singular_seen(singular_seen)
  );

  // offer one item and hold it until taken; busy is sampled mid-cycle where
  // it is stable, then a random gap follows
  task automatic send_matrix(m3i_pkg::in_t m);
    logic was_busy;
    int   gap, pick;
    start   <= 1'b1;
    in_data <= m;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    items_sent++;
    pick = $urandom_range(0, 99);
    if (pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain everything in flight, then let the pipe settle
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    wait (pending_inverses == 0);
    repeat (LATENCY_CYCLES + 4) @(posedge clk);
  endtask

  // threshold changes only with the pipe empty
  task automatic write_threshold(logic [30:0] thr);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 31'($urandom);
  endtask

  function automatic m3i_pkg::in_t make_matrix(logic signed [31:0] a, b, c, d, e, f,
                                               g, h, k);
    m3i_pkg::in_t m;
    m = '{a, b, c, d, e, f, g, h, k};
    return m;
  endfunction

  // element near a few units in Q16.16, so inverses land in range
  function automatic logic signed [31:0] modest_element();
    return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
  endfunction

  function automatic logic signed [31:0] wild_element();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return MAXV;
      1: return MINV;
      2: return 32'sh0;
      3: return 32'($signed($urandom_range(0, 31)) - 16);
      4: return ONE;
      5: return -ONE;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic m3i_pkg::in_t random_matrix();
    m3i_pkg::in_t m;
    int  kind, src, dst;
    logic signed [31:0] e [9];
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 9; i++) begin
      if (kind < 55) e[i] = modest_element();
      else if (kind < 75) e[i] = 32'($urandom);
      else e[i] = wild_element();
    end
    // copy a row or column so the determinant is exactly zero
    if (kind >= 90) begin
      src = $urandom_range(0, 2);
      dst = (src + $urandom_range(1, 2)) % 3;
      for (int i = 0; i < 3; i++) begin
        if (kind < 95) e[3 * dst + i] = e[3 * src + i];
        else e[3 * i + dst] = e[3 * i + src];
      end
    end
    m = make_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
    return m;
  endfunction

  initial begin
    #5_000_000;
    $display("FAIL matrix3x3_inverse");
    $finish;
  end

  initial begin
    logic [30:0] thr_pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset threshold of one
    send_matrix(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(make_matrix(2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, -8 * ONE));
    send_matrix('0);
    send_matrix(make_matrix(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
    send_matrix(make_matrix(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                            7 * ONE, 8 * ONE, 9 * ONE));
    send_matrix(make_matrix(2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE,
                            4 * ONE));
    send_matrix(make_matrix(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
    send_matrix(make_matrix(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
    send_matrix(make_matrix(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0));
    // small determinant: below the reset threshold, so both come out singular
    send_matrix(make_matrix(32'sd300, 0, 0, 0, 32'sd300, 0, 0, 0, 32'sd300));
    send_matrix(make_matrix(-32'sd300, ONE, 0, 0, 32'sd300, 0, 0, 0, 32'sd300));
    // thirds force a rounding decision; tiny raw threes and twos fall below the threshold
    send_matrix(make_matrix(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, -3 * ONE));
    send_matrix(make_matrix(32'sd3, 0, 0, 0, 32'sd2, 0, 0, 0, ONE));
    send_matrix(make_matrix(-ONE, -ONE, 0, ONE, -ONE, 0, 0, 0, -ONE));

    // threshold zero: tiny determinants pass, zero ones do not
    write_threshold(31'd0);
    send_matrix(make_matrix(32'sd1, 0, 0, 0, 32'sd1, 0, 0, 0, 32'sd1));
    send_matrix(make_matrix(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE));
    send_matrix('0);

    // threshold at its top: nearly everything singular
    write_threshold(31'h7FFF_FFFF);
    send_matrix(make_matrix(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV));
    send_matrix(make_matrix(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
    send_matrix(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));

    // threshold of exactly one determinant of one: right at the boundary
    write_threshold(31'(ONE));
    send_matrix(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_matrix(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE - 1));
    send_matrix(make_matrix(-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));

    // random part in phases with fresh thresholds between them
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: thr_pick = 31'd1;
        1: thr_pick = 31'd0;
        2: thr_pick = 31'($urandom_range(1, 32'h0004_0000));
        3: thr_pick = 31'h7FFF_FFFF;
        4: thr_pick = 31'($urandom);
        default: thr_pick = 31'($urandom_range(0, 255));
      endcase
      write_threshold(thr_pick);
      for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
        send_matrix(random_matrix());
        // one hold-off until the pipe has emptied completely
        if (phase == 2 && n == 40) begin
          start <= 1'b0;
          @(posedge clk);
          wait (pending_inverses == 0);
          @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    wait (pending_inverses == 0);
    repeat (LATENCY_CYCLES + 10) @(posedge clk);

    $display("sent %0d matrices over ten threshold settings", items_sent);
    $display("results: %0d invertible, %0d singular", invertible_seen,
             singular_seen);
    if (fail_count == 0 && pending_inverses == 0) begin
      $display("PASS matrix3x3_inverse");
    end else begin
      $display("FAIL matrix3x3_inverse");
    end
    $finish;
  end

endmodule

`default_nettype wire
